>>> hdl/mlpq_pkg.sv
package mlpq_pkg;

  // Queue geometry
  localparam int LEVELS       = 16;
  localparam int LEVEL_DEPTH  = 16;
  localparam int HANDLE_WIDTH = 16;

  // Fixed field widths of the transaction payloads
  localparam int PRIO_W = 4;
  localparam int HDL_W  = 16;
  localparam int STAT_W = 2;

  // Derived widths
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W = LVL_W + PTR_W;
  localparam int SLOT_DEPTH = 1 << ADDR_W;
  localparam int CMP_W  = (LVL_W + 1 > PRIO_W) ? LVL_W + 1 : PRIO_W;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              command;
    logic [PRIO_W-1:0] priority_req;
    logic [HDL_W-1:0]  item_handle;
  } in_item_t;

  typedef struct packed {
    logic [HDL_W-1:0]  out_handle;
    logic [PRIO_W-1:0] out_level;
    logic [STAT_W-1:0] status;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic enq_commit;
    logic deq_commit;
    logic deq_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_deq;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hdl/mlpq_ram.sv
module mlpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/mlpq_ctrl.sv
module mlpq_ctrl
  import mlpq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Sequence one transaction: capture, update pointers, load result
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.is_deq) begin
          cmd.deq_commit = 1'b1;
          state_nxt      = ST_LOAD;
        end else if (sts.out_free) begin
          cmd.enq_commit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.deq_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold off new transactions while one is in flight
  assign in_stall = (state_r != ST_IDLE);

  a_enq_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq_commit |-> sts.out_free)
    else $error("enqueue result loaded into occupied output register");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq_load |-> sts.out_free)
    else $error("dequeue result loaded into occupied output register");

  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_EXEC) && in_stall)
    else $error("captured transaction did not enter execution");

endmodule

>>> hdl/mlpq_dp.sv
module mlpq_dp
  import mlpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Captured transaction
  logic                    cmd_r;
  logic [PRIO_W-1:0]       prio_r;
  logic [HANDLE_WIDTH-1:0] handle_r;

  // Per-level FIFO pointers and occupancy
  logic [PTR_W-1:0] head_r [LEVELS];
  logic [PTR_W-1:0] tail_r [LEVELS];
  logic [CNT_W-1:0] cnt_r  [LEVELS];

  // Dequeue bookkeeping between commit and load
  logic             deq_hit_r;
  logic [LVL_W-1:0] deq_lvl_r;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  // Enqueue decode
  logic [LVL_W-1:0] enq_lvl;
  logic             enq_range;
  logic             enq_ok;
  logic [PTR_W-1:0] tail_cur;
  logic [PTR_W-1:0] tail_inc;

  // Dequeue search
  logic             deq_any;
  logic [LVL_W-1:0] deq_lvl;
  logic [PTR_W-1:0] head_cur;
  logic [PTR_W-1:0] head_inc;

  // Slot memory ports
  logic                    ram_we;
  logic                    ram_re;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [HANDLE_WIDTH-1:0] ram_rdata;

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r    <= in_data.command;
      prio_r   <= in_data.priority_req;
      handle_r <= HANDLE_WIDTH'(in_data.item_handle);
    end
  end

  // Check the enqueue level for range and room
  assign enq_lvl   = LVL_W'(prio_r);
  assign enq_range = CMP_W'(prio_r) < CMP_W'(LEVELS);
  assign enq_ok    = enq_range && (cnt_r[enq_lvl] != CNT_W'(LEVEL_DEPTH));
  assign tail_cur  = tail_r[enq_lvl];
  assign tail_inc  = (tail_cur == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : tail_cur + 1'b1;

  // Find the most urgent non-empty level
  always_comb begin
    deq_any = 1'b0;
    deq_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        deq_any = 1'b1;
        deq_lvl = LVL_W'(i);
      end
    end
  end

  assign head_cur = head_r[deq_lvl];
  assign head_inc = (head_cur == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : head_cur + 1'b1;

  // Advance pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (cmd.enq_commit && enq_ok) begin
      tail_r[enq_lvl] <= tail_inc;
      cnt_r[enq_lvl]  <= cnt_r[enq_lvl] + 1'b1;
    end else if (cmd.deq_commit && deq_any) begin
      head_r[deq_lvl] <= head_inc;
      cnt_r[deq_lvl]  <= cnt_r[deq_lvl] - 1'b1;
    end
  end

  // Remember the dequeue outcome until the slot data returns
  always_ff @(posedge clk) begin
    if (cmd.deq_commit) begin
      deq_hit_r <= deq_any;
      deq_lvl_r <= deq_lvl;
    end
  end

  // Slot memory access
  assign ram_we    = cmd.enq_commit && enq_ok;
  assign ram_waddr = {enq_lvl, tail_cur};
  assign ram_re    = cmd.deq_commit && deq_any;
  assign ram_raddr = {deq_lvl, head_cur};

  mlpq_ram #(
    .WIDTH(HANDLE_WIDTH),
    .DEPTH(SLOT_DEPTH)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(handle_r),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Build the result and manage the output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.enq_commit) begin
      out_nxt.out_handle = '0;
      out_nxt.out_level  = '0;
      out_nxt.status     = enq_ok ? STAT_OK : STAT_FULL;
      out_valid_nxt      = 1'b1;
    end else if (cmd.deq_load) begin
      if (deq_hit_r) begin
        out_nxt.out_handle = HDL_W'(ram_rdata);
        out_nxt.out_level  = PRIO_W'(deq_lvl_r);
        out_nxt.status     = STAT_OK;
      end else begin
        out_nxt.out_handle = '0;
        out_nxt.out_level  = '0;
        out_nxt.status     = STAT_EMPTY;
      end
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.is_deq   = (cmd_r == CMD_DEQ);
  assign sts.out_free = !out_valid_r || !out_stall;

  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("slot memory written and read in the same cycle");

  a_enq_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq_commit |=> out_valid_r && (out_r.out_handle == '0))
    else $error("enqueue result missing or carries a handle");

endmodule

>>> hdl/multilevel_priority_fifo_queue.sv
// Sequence: an accepted transaction is captured, then the level pointers are updated. An enqueue
//   result is loaded into the output register with the pointer update, a dequeue result after
//   the registered read of the shared slot memory; both wait while the output register is held.
// Throughput: a new transaction is accepted only once the previous result has been loaded.
// Reset: rst_n (synchronous, active low) empties every level and clears the output valid;
//   slot memory contents are not cleared and are only read once written.
module multilevel_priority_fifo_queue
  import mlpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mlpq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  mlpq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

>>> test/multilevel_priority_fifo_queue_tb.sv
module multilevel_priority_fifo_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlpq_pkg::*;

  localparam int RANDOM_OPS   = 700;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD    = 400;

  typedef struct {
    in_item_t op;
    bit       drain_first;
  } sched_op_t;

  typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_SPARSE} stall_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Scheduler operations waiting to be offered, and results predicted for accepted ones
  sched_op_t queued_ops[$];
  out_item_t predicted_results[$];

  // Predictor state: ready handles held per priority level, oldest first
  logic [HANDLE_WIDTH-1:0] level_fifo[LEVELS][$];

  int ops_accepted = 0;
  int results_seen = 0;
  int error_count = 0;
  int total_ops;

  // Sender burst state
  int burst_left = 1;
  int gap_left = 0;

  // Receiver stall state
  stall_mode_t stall_mode = STALL_NONE;
  int mode_left = 0;
  int stall_phase = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  multilevel_priority_fifo_queue i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Apply one accepted operation to the ready queue and record its result
  task automatic predict_sched_result(input in_item_t item);
    out_item_t res;
    int lvl;
    bit found;
    res = '0;
    found = 1'b0;
    if (item.command == CMD_ENQ) begin
      lvl = int'(item.priority_req);
      if (lvl >= LEVELS || level_fifo[lvl].size() >= LEVEL_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        level_fifo[lvl].push_back(item.item_handle[HANDLE_WIDTH-1:0]);
        res.status = STAT_OK;
      end
    end else begin
      res.status = STAT_EMPTY;
      for (lvl = 0; lvl < LEVELS; lvl++) begin
        if (!found && level_fifo[lvl].size() != 0) begin
          found = 1'b1;
          res.out_handle = HDL_W'(level_fifo[lvl].pop_front());
          res.out_level  = PRIO_W'(lvl);
          res.status     = STAT_OK;
        end
      end
    end
    predicted_results.push_back(res);
  endtask

  task automatic check_sched_result(input out_item_t got);
    out_item_t want;
    if (predicted_results.size() == 0) begin
      report_mismatch("result with nothing pending", 32'(got), '0);
      return;
    end
    want = predicted_results.pop_front();
    if (got.out_handle !== want.out_handle)
      report_mismatch("out_handle", 32'(got.out_handle), 32'(want.out_handle));
    if (got.out_level !== want.out_level)
      report_mismatch("out_level", 32'(got.out_level), 32'(want.out_level));
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
  endtask

  task automatic add_enq(input int prio, input logic [HDL_W-1:0] handle, input bit drain);
    sched_op_t s;
    s.op.command      = CMD_ENQ;
    s.op.priority_req = PRIO_W'(prio);
    s.op.item_handle  = handle;
    s.drain_first     = drain;
    queued_ops.push_back(s);
  endtask

  // Dequeue carries random priority and handle bits, which the block ignores
  task automatic add_deq(input bit drain);
    sched_op_t s;
    s.op.command      = CMD_DEQ;
    s.op.priority_req = PRIO_W'($urandom);
    s.op.item_handle  = HDL_W'($urandom);
    s.drain_first     = drain;
    queued_ops.push_back(s);
  endtask

  function automatic logic [HDL_W-1:0] pick_handle();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return HDL_W'($urandom);
    endcase
  endfunction

  // Driver: offer queued operations in bursts, hold a stalled transaction
  always @(posedge clk) begin
    bit taken;
    bit drained;
    sched_op_t next_op;
    taken = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (taken) begin
        predict_sched_result(in_data);
        ops_accepted <= ops_accepted + 1;
      end
      if (taken || !in_valid) begin
        drained = (ops_accepted + int'(taken)) == results_seen;
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_ops.size() == 0 || (queued_ops[0].drain_first && !drained)) begin
          in_valid <= 1'b0;
        end else begin
          next_op = queued_ops.pop_front();
          in_data  <= next_op.op;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                    : $urandom_range(0, 3);
          end
        end
      end
    end
  end

  // Monitor: check every result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_sched_result(out_data);
      results_seen <= results_seen + 1;
    end
  end

  // Receiver stall pattern, with one long hold-off to back up the queue
  always @(posedge clk) begin
    if (!long_hold_done && ops_accepted >= LONG_HOLD_AT) begin
      hold_left = LONG_HOLD;
      long_hold_done = 1'b1;
    end
    stall_phase++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_COIN:     out_stall <= ($urandom_range(0, 1) == 1);
        STALL_PERIODIC: out_stall <= (stall_phase % 3) != 0;
        default:        out_stall <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    int rand_ops;
    int seg_len;
    int enq_pct;
    int lo;
    int hi;
    bit drain;

    // Empty queue, extreme handles and levels, strict level order
    add_deq(1'b0);
    add_enq(0, '0, 1'b0);
    add_enq(LEVELS - 1, '1, 1'b0);
    add_enq(9, 16'hA5A5, 1'b0);
    add_deq(1'b0);
    add_deq(1'b0);
    add_deq(1'b0);
    add_deq(1'b0);
    // Fill one level to capacity from an idle block, then overflow it
    for (int k = 0; k < LEVEL_DEPTH; k++) add_enq(5, pick_handle(), k == 0);
    add_enq(5, 16'h5A5A, 1'b0);

    // Random segments: balanced, fill narrow level bands, drain, fill all levels
    rand_ops = 0;
    while (rand_ops < RANDOM_OPS) begin
      seg_len = $urandom_range(20, 60);
      lo = 0;
      hi = LEVELS - 1;
      case ($urandom_range(0, 3))
        0: enq_pct = 50;
        1: begin
          enq_pct = 85;
          lo = $urandom_range(0, LEVELS - 1);
          hi = lo + $urandom_range(0, 2);
          if (hi > LEVELS - 1) hi = LEVELS - 1;
        end
        2: enq_pct = 15;
        default: enq_pct = 75;
      endcase
      for (int k = 0; k < seg_len; k++) begin
        drain = (k == 0) && ($urandom_range(0, 3) == 0);
        if ($urandom_range(1, 100) <= enq_pct)
          add_enq($urandom_range(lo, hi), pick_handle(), drain);
        else
          add_deq(drain);
      end
      rand_ops += seg_len;
    end
    total_ops = queued_ops.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every result, then give the block time to show stray ones
    do @(posedge clk); while (results_seen < total_ops);
    repeat (10) @(posedge clk);
    if (predicted_results.size() != 0)
      report_mismatch("results never delivered", 32'(predicted_results.size()), '0);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #200_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
